@@ rtl/cde_pkg.sv @@
// Shared types and codes for the circular deque engine.
package cde_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } deq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } deq_status_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic     enable;
    deq_cmd_e cmd;
  } deq_cell_ctrl_t;

endpackage

@@ rtl/circular_deque_engine.sv @@
// Double-ended queue of DEPTH words built as a chain of shifting cells.
// The front entry always sits in cell 0; pushes and pops at the front shift the
// whole chain by one cell, and the rear entry is the last occupied cell. Each
// request yields one result beat with status, popped word and empty/full flags.
// The rear word reaches cell 0 over a registered tap chain that moves one cell
// per cycle, so a pop at the rear is held off until that chain has settled after
// the last change of contents. A refused or underflowing request changes nothing.
module circular_deque_engine import cde_pkg::*; #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] pop_value_o,
  output logic               now_empty_o,
  output logic               now_full_o
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  deq_cmd_e                 cmd;
  deq_cell_ctrl_t           ctrl;
  logic                     accept, out_free, settled;
  logic                     is_empty, is_full, op_ok, is_push;
  logic [CW-1:0]            count_q, count_d, settle_q, settle_d;
  logic [EXT_W-1:0]         word_ext, pop_ext;
  logic [DATA_WIDTH-1:0]    word;
  logic [DEPTH-1:0]         cell_valid;
  logic [DATA_WIDTH-1:0]    cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]    cell_tap  [DEPTH];

  logic                     out_valid_q, out_valid_d;
  deq_status_e              status_q, status_d;
  logic [DATA_WIDTH-1:0]    pop_q, pop_d;
  logic                     empty_q, full_q;

  assign cmd      = deq_cmd_e'(kind_i);
  assign word_ext = EXT_W'($unsigned(push_value_i));
  assign word     = word_ext[DATA_WIDTH-1:0];

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
  assign op_ok    = is_push ? !is_full : !is_empty;
  assign settled  = (settle_q == CW'(DEPTH));

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free || ((cmd == CMD_POP_REAR) && !settled);
  assign accept     = in_valid_i && !in_stall_o;

  assign ctrl.enable = accept && op_ok;
  assign ctrl.cmd    = cmd;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv, rv;
    logic [DATA_WIDTH-1:0] ld, rd, rt;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = word;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
      assign rt = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
      assign rt = cell_tap[i+1];
    end
    cde_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .word_i       (word),
      .left_valid_i (lv),
      .left_data_i  (ld),
      .right_valid_i(rv),
      .right_data_i (rd),
      .tap_i        (rt),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i]),
      .tap_o        (cell_tap[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.enable) begin
      count_d = is_push ? count_q + CW'(1) : count_q - CW'(1);
    end
    // restart the rear tap settle count on any change of contents
    if (ctrl.enable) begin
      settle_d = '0;
    end else if (settled) begin
      settle_d = settle_q;
    end else begin
      settle_d = settle_q + CW'(1);
    end
  end

  always_comb begin
    status_d = ST_OK;
    pop_d    = '0;
    if (!op_ok) begin
      status_d = is_push ? ST_OVER : ST_UNDER;
    end else if (cmd == CMD_POP_FRONT) begin
      pop_d = cell_data[0];
    end else if (cmd == CMD_POP_REAR) begin
      pop_d = cell_tap[0];
    end
    if (accept) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      settle_q    <= CW'(DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      settle_q    <= settle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pop_q    <= pop_d;
      empty_q  <= (count_d == '0);
      full_q   <= (count_d == CW'(DEPTH));
    end
  end

  assign pop_ext     = EXT_W'(pop_q);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign pop_value_o = pop_ext[31:0];
  assign now_empty_o = empty_q;
  assign now_full_o  = full_q;

endmodule

@@ rtl/cde_cell.sv @@
// One storage cell of the deque chain: holds a word, shifts with its neighbors.
module cde_cell import cde_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  deq_cell_ctrl_t        ctrl_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  right_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic [DATA_WIDTH-1:0] tap_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] tap_q, tap_d;
  logic                  is_last;

  assign is_last = valid_q && !right_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.enable) begin
      case (ctrl_i.cmd)
        CMD_PUSH_FRONT: begin
          valid_d = left_valid_i;
          data_d  = left_data_i;
        end
        CMD_PUSH_REAR: begin
          // first free slot takes the word
          if (!valid_q && left_valid_i) begin
            valid_d = 1'b1;
            data_d  = word_i;
          end
        end
        CMD_POP_FRONT: begin
          valid_d = right_valid_i;
          data_d  = right_data_i;
        end
        CMD_POP_REAR: begin
          if (is_last) begin
            valid_d = 1'b0;
          end
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  // Hand the rear word toward cell 0, one cell per cycle.
  assign tap_d = is_last ? data_q : tap_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tap_q  <= tap_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign tap_o   = tap_q;

endmodule

@@ rtl/cde_checker.sv @@
// Port-level checks for the circular deque engine, bound to the top level.
module cde_checker import cde_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] pop_value_o,
  input logic               now_empty_o,
  input logic               now_full_o
);

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(now_empty_o && now_full_o))
    else $error("deque reports empty and full at once");

  a_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_UNDER) |-> (now_empty_o && pop_value_o == 32'sd0))
    else $error("underflow beat with data or non-empty deque");

  a_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OVER) |-> (now_full_o && pop_value_o == 32'sd0))
    else $error("overflow beat with data or non-full deque");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(pop_value_o)))
    else $error("stalled result beat changed");

endmodule

bind circular_deque_engine cde_checker u_cde_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .pop_value_o(pop_value_o),
  .now_empty_o(now_empty_o),
  .now_full_o (now_full_o)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for circular_deque_engine: directed and random requests, stalls.
`timescale 1ns / 1ps

module tb_top;
  import cde_pkg::*;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 20;

  typedef struct {
    deq_status_e        status;
    logic signed [31:0] pop_value;
    logic               now_empty;
    logic               now_full;
  } deq_result_t;

  // Deque predictor plus the queue of results it still owes.
  class deque_checker;
    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
    int unsigned           front_at;
    int unsigned           rear_at;
    bit                    empty_flag;
    deq_result_t           pending_results[$];
    int                    error_count;

    function new();
      front_at    = 0;
      rear_at     = 0;
      empty_flag  = 1'b1;
      error_count = 0;
    endfunction

    function bit is_full();
      return !empty_flag && front_at == (rear_at + 1) % DEPTH;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_request(deq_cmd_e cmd, logic signed [31:0] word);
      deq_result_t r;
      r.status    = ST_OK;
      r.pop_value = '0;
      if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
        if (is_full()) begin
          r.status = ST_OVER;
        end else if (empty_flag) begin
          front_at    = 0;
          rear_at     = 0;
          empty_flag  = 1'b0;
          slot_mem[0] = word[DATA_WIDTH-1:0];
        end else if (cmd == CMD_PUSH_FRONT) begin
          front_at           = (front_at + DEPTH - 1) % DEPTH;
          slot_mem[front_at] = word[DATA_WIDTH-1:0];
        end else begin
          rear_at           = (rear_at + 1) % DEPTH;
          slot_mem[rear_at] = word[DATA_WIDTH-1:0];
        end
      end else begin
        if (empty_flag) begin
          r.status = ST_UNDER;
        end else begin
          r.pop_value = slot_mem[(cmd == CMD_POP_FRONT) ? front_at : rear_at];
          // Last entry gone: both pointers go back to zero.
          if (front_at == rear_at) begin
            front_at   = 0;
            rear_at    = 0;
            empty_flag = 1'b1;
          end else if (cmd == CMD_POP_FRONT) begin
            front_at = (front_at + 1) % DEPTH;
          end else begin
            rear_at = (rear_at + DEPTH - 1) % DEPTH;
          end
        end
      end
      r.now_empty = empty_flag;
      r.now_full  = is_full();
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic signed [31:0] pop_value,
                               logic now_empty, logic now_full);
      deq_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no request pending (status %0d value %0h)",
                 $time, status, pop_value);
        error_count++;
        return;
      end
      r = pending_results.pop_front();
      if (status !== r.status) begin
        $display("%0t: status expected %0d got %0d", $time, r.status, status);
        error_count++;
      end
      if (pop_value !== r.pop_value) begin
        $display("%0t: pop_value expected %0h got %0h", $time, r.pop_value, pop_value);
        error_count++;
      end
      if (now_empty !== r.now_empty) begin
        $display("%0t: now_empty expected %0b got %0b", $time, r.now_empty, now_empty);
        error_count++;
      end
      if (now_full !== r.now_full) begin
        $display("%0t: now_full expected %0b got %0b", $time, r.now_full, now_full);
        error_count++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  deq_cmd_e           req_kind = CMD_PUSH_FRONT;
  logic signed [31:0] req_value = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [1:0]         rsp_status;
  logic signed [31:0] rsp_value;
  logic               rsp_empty;
  logic               rsp_full;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  deque_checker board = new();

  circular_deque_engine #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .kind_i      (req_kind),
    .push_value_i(req_value),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .status_o    (rsp_status),
    .pop_value_o (rsp_value),
    .now_empty_o (rsp_empty),
    .now_full_o  (rsp_full)
  );

  always #5 clk = ~clk;

  // Receiver: long hold-off first, otherwise random stall.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall = 1'b1;
      hold_cycles--;
    end else begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_valid && !rsp_stall)
      board.check_result(rsp_status, rsp_value, rsp_empty, rsp_full);
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(input deq_cmd_e cmd, input logic signed [31:0] word);
    // idle one cycle at a time so the idle share matches the percentage
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_kind  = cmd;
    req_value = word;
    do @(posedge clk); while (req_stall);
    board.note_request(cmd, word);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  // Bursts lean toward pushes or pops so full and empty are both hit often.
  task automatic run_random(input int count);
    int push_pct;
    logic signed [31:0] word;
    deq_cmd_e cmd;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 12 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      case ($urandom_range(9))
        0: word = 32'sh7fff_ffff;
        1: word = 32'sh8000_0000;
        2: word = '0;
        3: word = -32'sd1;
        default: word = $urandom;
      endcase
      if ($urandom_range(99) < push_pct)
        cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
      send_request(cmd, word);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Underflow on both ends, push on empty at the front, pop of last entry.
    send_request(CMD_POP_FRONT, 32'sh1111_1111);
    send_request(CMD_POP_REAR, 32'sh2222_2222);
    send_request(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(CMD_POP_REAR, '0);
    // Push on empty at the rear, fill to the brim, then overflow at both ends.
    send_request(CMD_PUSH_REAR, 32'sh8000_0000);
    send_request(CMD_PUSH_FRONT, -32'sd1);
    send_request(CMD_PUSH_REAR, '0);
    send_request(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(CMD_PUSH_REAR, 32'sh5555_5555);
    send_request(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
    send_request(CMD_PUSH_REAR, 32'sd1);
    send_request(CMD_PUSH_FRONT, 32'sh1234_5678);
    send_request(CMD_PUSH_FRONT, 32'sh0bad_0bad);
    send_request(CMD_PUSH_REAR, 32'sh0bad_0bad);
    // Drain alternating ends, then one more underflow.
    for (int i = 0; i < DEPTH; i++)
      send_request(i % 2 ? CMD_POP_FRONT : CMD_POP_REAR, 32'sh6666_6666);
    send_request(CMD_POP_FRONT, '0);

    // No idling; long receiver hold-off fills the block, then a full drain pause.
    run_random(140);
    hold_cycles = 80;
    run_random(40);
    wait_drained();
    run_random(100);

    send_idle_pct = 74;
    recv_stall_pct = 0;
    run_random(270);

    send_idle_pct = 0;
    recv_stall_pct = 74;
    run_random(270);

    send_idle_pct = 25;
    recv_stall_pct = 25;
    run_random(270);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.error_count == 0 && board.outstanding() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ circular_deque_engine.f @@
rtl/cde_pkg.sv
rtl/cde_cell.sv
rtl/circular_deque_engine.sv
rtl/cde_checker.sv
tb/tb_top.sv
